/* src/crclog_pkg.sv */
// ----------------------------------------------------------------------------
// crclog_pkg
// Shared constants, codes and types of the CRC log record framer/checker.
// ----------------------------------------------------------------------------
package crclog_pkg;

    // Log geometry
    localparam int SLOT_BYTES = 64;
    localparam int SLOT_COUNT = 32;
    localparam int TEXT_MAX   = SLOT_BYTES - 3;

    // Field and counter widths
    localparam int ADDR_W = 11;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int ACT_W  = 2;
    localparam int POS_W  = $clog2(SLOT_BYTES + 3);
    localparam int TPOS_W = $clog2(SLOT_BYTES);
    localparam int SLOT_W = $clog2(SLOT_COUNT + 1);
    localparam int SUM_W  = SLOT_W + POS_W + $clog2(SLOT_BYTES);
    localparam int CRC_W  = 16;
    localparam int BIT_W  = $clog2(BYTE_W);

    // CRC-16/CCITT
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // Request action codes
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CHECK = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ERASE = 2'd2;

    // Which frame is open
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_CHECK = 2'd2
    } frame_kind_t;

    // Control toward the serial CRC unit
    typedef struct packed {
        logic              clear;
        logic              start;
        logic [BYTE_W-1:0] data;
    } crc_ctrl_t;

    // One result item
    typedef struct packed {
        logic [ADDR_W-1:0] log_addr;
        logic [BYTE_W-1:0] write_data;
        logic              is_write;
        logic              slot_valid;
        logic [LEN_W-1:0]  text_length;
        logic              last_result;
    } result_t;

    // Byte address of position pos in slot slot
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [POS_W-1:0]  pos);
        logic [SUM_W-1:0] full;
        full = SUM_W'(slot) * SUM_W'(SLOT_BYTES) + SUM_W'(pos);
        return full[ADDR_W-1:0];
    endfunction

endpackage

/* src/crclog_crc_serial.sv */
// ----------------------------------------------------------------------------
// crclog_crc_serial
// Bit-serial CRC-16/CCITT: folds one byte into the running CRC, MSB first,
// one bit per cycle.
// ----------------------------------------------------------------------------
module crclog_crc_serial
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  crclog_pkg::crc_ctrl_t          ctrl,
    output logic                           busy,
    output logic [crclog_pkg::CRC_W-1:0]   crc
);
    import crclog_pkg::*;

    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic              busy_reg, busy_next;
    logic              fb;

    // One shift step per cycle while busy
    always_comb
    begin
        crc_next     = crc_reg;
        data_next    = data_reg;
        bit_cnt_next = bit_cnt_reg;
        busy_next    = busy_reg;
        fb           = crc_reg[CRC_W-1] ^ data_reg[BYTE_W-1];
        if (ctrl.clear)
        begin
            crc_next  = CRC_INIT;
            busy_next = 1'b0;
        end
        else if (ctrl.start)
        begin
            data_next    = ctrl.data;
            bit_cnt_next = '0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            crc_next     = {crc_reg[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
            data_next    = {data_reg[BYTE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + BIT_W'(1);
            if (bit_cnt_reg == BIT_W'(BYTE_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_INIT;
            busy_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            crc_reg     <= crc_next;
            busy_reg    <= busy_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    // Shifted data byte, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign busy = busy_reg;
    assign crc  = crc_reg;

endmodule

/* src/crclog_out_stage.sv */
// ----------------------------------------------------------------------------
// crclog_out_stage
// Output holding register: keeps one result until the consumer takes it.
// ----------------------------------------------------------------------------
module crclog_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  crclog_pkg::result_t   push_res,
    output logic                  can_push,
    output logic                  out_valid,
    input  logic                  out_ready,
    output crclog_pkg::result_t   res
);
    import crclog_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // Slot frees when empty or being taken this cycle
    assign can_push = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

/* src/crc_log_record_framer_checker_core.sv */
// ----------------------------------------------------------------------------
// crc_log_record_framer_checker_core
// Frames text into CRC-16 protected 64-byte log slots, checks stored slots,
// and erases the log.
// Flow: writes and verdicts are pushed into the output register; a check
//   verdict comes from S_VERD, after S_CWAIT if the final slot byte runs
//   through the bit-serial CRC unit. Requests are taken only in S_IDLE, once
//   the last one is done. A final text byte also folds the terminator into
//   the CRC, then writes it and both CRC bytes; erase gives one write per
//   cycle per used slot while the output can take it.
// Reset: slot index 0, CRC 0xFFFF, no frame open, output empty.
// ----------------------------------------------------------------------------
module crc_log_record_framer_checker_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [crclog_pkg::ACT_W-1:0]      action,
    input  logic [crclog_pkg::BYTE_W-1:0]     data_byte,
    input  logic                              last_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [crclog_pkg::ADDR_W-1:0]     log_addr,
    output logic [crclog_pkg::BYTE_W-1:0]     write_data,
    output logic                              is_write,
    output logic                              slot_valid,
    output logic [crclog_pkg::LEN_W-1:0]      text_length,
    output logic                              last_result
);
    import crclog_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ERASE = 9'b000000010,
        S_WDATA = 9'b000000100,
        S_WCRC  = 9'b000001000,
        S_WZERO = 9'b000010000,
        S_WTAIL = 9'b000100000,
        S_CHK   = 9'b001000000,
        S_CWAIT = 9'b010000000,
        S_VERD  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    frame_kind_t       kind_reg, kind_next;
    logic [SLOT_W-1:0] slot_index_reg, slot_index_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [TPOS_W-1:0] tpos_reg, tpos_next;
    logic              tseen_reg, tseen_next;
    logic              fbn_reg, fbn_next;
    logic              matched_reg, matched_next;
    logic              match_pend_reg, match_pend_next;
    logic [SLOT_W-1:0] erase_cnt_reg, erase_cnt_next;
    logic [SLOT_W-1:0] erase_used_reg, erase_used_next;
    logic [1:0]        tail_cnt_reg, tail_cnt_next;
    logic [ACT_W-1:0]  act_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    logic              accept;
    logic              clear_frame;
    crc_ctrl_t         crc_ctrl;
    logic              crc_busy;
    logic [CRC_W-1:0]  crc_val;
    logic              push;
    result_t           push_res;
    logic              can_push;
    result_t           res;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    crclog_crc_serial u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .busy  (crc_busy),
        .crc   (crc_val)
    );

    crclog_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    // Request sequencer
    always_comb
    begin
        logic [POS_W-1:0] tpos_plus2;
        logic             verdict;

        state_next      = state_reg;
        kind_next       = kind_reg;
        slot_index_next = slot_index_reg;
        pos_next        = pos_reg;
        tpos_next       = tpos_reg;
        tseen_next      = tseen_reg;
        fbn_next        = fbn_reg;
        matched_next    = matched_reg;
        match_pend_next = match_pend_reg;
        erase_cnt_next  = erase_cnt_reg;
        erase_used_next = erase_used_reg;
        tail_cnt_next   = tail_cnt_reg;
        clear_frame     = 1'b0;
        crc_ctrl        = '0;
        push            = 1'b0;
        push_res        = '0;
        tpos_plus2      = {1'b0, tpos_reg} + POS_W'(2);
        verdict         = fbn_reg && tseen_reg && matched_reg &&
                          ({1'b0, tpos_reg} < POS_W'(SLOT_BYTES - 2));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    erase_cnt_next  = '0;
                    erase_used_next = (slot_index_reg > SLOT_W'(SLOT_COUNT)) ?
                                      SLOT_W'(SLOT_COUNT) : slot_index_reg;
                    priority if (action == ACT_WRITE)
                    begin
                        if (kind_reg != KIND_WRITE)
                        begin
                            clear_frame = 1'b1;
                            state_next  = (slot_index_reg >= SLOT_W'(SLOT_COUNT)) ?
                                          S_ERASE : S_WDATA;
                        end
                        else
                        begin
                            state_next = S_WDATA;
                        end
                    end
                    else if (action == ACT_CHECK)
                    begin
                        if (kind_reg != KIND_CHECK)
                        begin
                            clear_frame = 1'b1;
                        end
                        state_next = S_CHK;
                    end
                    else if (action == ACT_ERASE)
                    begin
                        clear_frame = 1'b1;
                        kind_next   = KIND_NONE;
                        if (slot_index_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_ERASE;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                    // Frame kind after this request
                    if (action == ACT_WRITE)
                    begin
                        kind_next = KIND_WRITE;
                    end
                    else if (action == ACT_CHECK)
                    begin
                        kind_next = KIND_CHECK;
                    end
                end
            end

            // One zero write at the first byte of each used slot
            S_ERASE:
            begin
                if (can_push)
                begin
                    push                   = 1'b1;
                    push_res.log_addr      = slot_addr(erase_cnt_reg, '0);
                    push_res.is_write      = 1'b1;
                    push_res.last_result   = (act_reg == ACT_ERASE) &&
                        (erase_cnt_reg == erase_used_reg - SLOT_W'(1));
                    erase_cnt_next         = erase_cnt_reg + SLOT_W'(1);
                    if (erase_cnt_reg == erase_used_reg - SLOT_W'(1))
                    begin
                        slot_index_next = '0;
                        state_next      = (act_reg == ACT_ERASE) ? S_IDLE : S_WDATA;
                    end
                end
            end

            // Text byte write, then its CRC; a byte past TEXT_MAX is dropped
            S_WDATA:
            begin
                if (pos_reg < POS_W'(TEXT_MAX))
                begin
                    if (can_push)
                    begin
                        push                   = 1'b1;
                        push_res.log_addr      = slot_addr(slot_index_reg, pos_reg);
                        push_res.write_data    = byte_reg;
                        push_res.is_write      = 1'b1;
                        push_res.last_result   = !last_reg;
                        crc_ctrl.start         = 1'b1;
                        crc_ctrl.data          = byte_reg;
                        pos_next               = pos_reg + POS_W'(1);
                        state_next             = S_WCRC;
                    end
                end
                else if (last_reg)
                begin
                    crc_ctrl.start = 1'b1;
                    state_next     = S_WZERO;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_WCRC:
            begin
                if (!crc_busy)
                begin
                    if (last_reg)
                    begin
                        crc_ctrl.start = 1'b1;
                        state_next     = S_WZERO;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Terminator folded into the CRC
            S_WZERO:
            begin
                if (!crc_busy)
                begin
                    tail_cnt_next = '0;
                    state_next    = S_WTAIL;
                end
            end

            // Terminator, CRC high byte, CRC low byte
            S_WTAIL:
            begin
                if (can_push)
                begin
                    push                   = 1'b1;
                    push_res.log_addr      = slot_addr(slot_index_reg,
                                                       pos_reg + POS_W'(tail_cnt_reg));
                    push_res.is_write      = 1'b1;
                    unique case (tail_cnt_reg)
                        2'd0:    push_res.write_data = '0;
                        2'd1:    push_res.write_data = crc_val[CRC_W-1:BYTE_W];
                        default: push_res.write_data = crc_val[BYTE_W-1:0];
                    endcase
                    tail_cnt_next = tail_cnt_reg + 2'd1;
                    if (tail_cnt_reg == 2'd2)
                    begin
                        push_res.last_result = 1'b1;
                        slot_index_next      = slot_index_reg + SLOT_W'(1);
                        clear_frame          = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
            end

            // Slot byte scan
            S_CHK:
            begin
                state_next = last_reg ? S_VERD : S_IDLE;
                if (pos_reg < POS_W'(SLOT_BYTES))
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (pos_reg == '0)
                    begin
                        fbn_next = (byte_reg != '0);
                    end
                    if (!tseen_reg)
                    begin
                        crc_ctrl.start  = 1'b1;
                        crc_ctrl.data   = byte_reg;
                        match_pend_next = 1'b0;
                        state_next      = S_CWAIT;
                        if (byte_reg == '0)
                        begin
                            tseen_next = 1'b1;
                            tpos_next  = pos_reg[TPOS_W-1:0];
                        end
                    end
                    else if (pos_reg <= tpos_plus2)
                    begin
                        crc_ctrl.start  = 1'b1;
                        crc_ctrl.data   = byte_reg;
                        match_pend_next = (pos_reg == tpos_plus2);
                        state_next      = S_CWAIT;
                    end
                end
            end

            S_CWAIT:
            begin
                if (!crc_busy)
                begin
                    if (match_pend_reg)
                    begin
                        matched_next = (crc_val == '0);
                    end
                    state_next = last_reg ? S_VERD : S_IDLE;
                end
            end

            S_VERD:
            begin
                if (can_push)
                begin
                    push                 = 1'b1;
                    push_res.slot_valid  = verdict;
                    push_res.text_length = verdict ? LEN_W'(tpos_reg) : '0;
                    push_res.last_result = 1'b1;
                    clear_frame          = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Frame clear
        if (clear_frame)
        begin
            crc_ctrl.clear = 1'b1;
            pos_next       = '0;
            tpos_next      = '0;
            tseen_next     = 1'b0;
            fbn_next       = 1'b0;
            matched_next   = 1'b0;
            if (state_reg != S_IDLE)
            begin
                kind_next = KIND_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= KIND_NONE;
            slot_index_reg <= '0;
            pos_reg        <= '0;
            tpos_reg       <= '0;
            tseen_reg      <= 1'b0;
            fbn_reg        <= 1'b0;
            matched_reg    <= 1'b0;
            match_pend_reg <= 1'b0;
            erase_cnt_reg  <= '0;
            erase_used_reg <= '0;
            tail_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            slot_index_reg <= slot_index_next;
            pos_reg        <= pos_next;
            tpos_reg       <= tpos_next;
            tseen_reg      <= tseen_next;
            fbn_reg        <= fbn_next;
            matched_reg    <= matched_next;
            match_pend_reg <= match_pend_next;
            erase_cnt_reg  <= erase_cnt_next;
            erase_used_reg <= erase_used_next;
            tail_cnt_reg   <= tail_cnt_next;
        end
    end

    // Captured request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign log_addr    = res.log_addr;
    assign write_data  = res.write_data;
    assign is_write    = res.is_write;
    assign slot_valid  = res.slot_valid;
    assign text_length = res.text_length;
    assign last_result = res.last_result;

endmodule

/* tb/crc_log_record_framer_checker_core_tb.sv */
// ----------------------------------------------------------------------------
// crc_log_record_framer_checker_core_tb
// Self-checking bench for the CRC-16 log framer/checker. A short directed
// sequence and then random record, slot-check, erase and noise requests are
// streamed through the request channel. A built-in log model predicts every
// memory write and check verdict, and results are matched in order. Both
// handshakes idle and stall at random. One phase holds the result side off
// long enough to back the block up.
// ----------------------------------------------------------------------------
module crc_log_record_framer_checker_core_tb;

    import crclog_pkg::*;

    // Action code the block ignores
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned HOLD_CYCLES = 1500;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned REPORT_CAP  = 40;

    // Ways a stored slot image can be damaged before it is checked
    typedef enum int {
        FLAW_NONE,
        FLAW_CORRUPT,
        FLAW_LEAD_ZERO,
        FLAW_EARLY,
        FLAW_NO_TERM,
        FLAW_PAD,
        FLAW_LATE_TERM
    } slot_flaw_t;

    // ------------------------------------------------------------------------
    // Log model and result scoreboard
    // ------------------------------------------------------------------------
    class log_scoreboard;
        result_t           expected_q[$];
        int unsigned       mismatches;
        logic [SLOT_W-1:0] slot_index;
        logic [CRC_W-1:0]  crc;
        logic [POS_W-1:0]  pos;
        logic [TPOS_W-1:0] term_pos;
        logic              term_seen;
        logic              lead_nonzero;
        logic              crc_good;
        frame_kind_t       kind;

        function new();
            mismatches = 0;
            slot_index = '0;
            drop_frame();
        endfunction

        // CRC-16/CCITT, MSB first, one byte
        static function logic [CRC_W-1:0] crc_next(logic [CRC_W-1:0] c, logic [7:0] b);
            logic [CRC_W-1:0] r;
            r = c ^ {b, 8'h00};
            for (int i = 0; i < 8; i++)
                r = r[CRC_W-1] ? ({r[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {r[CRC_W-2:0], 1'b0};
            return r;
        endfunction

        function void drop_frame();
            crc          = CRC_INIT;
            pos          = '0;
            term_pos     = '0;
            term_seen    = 1'b0;
            lead_nonzero = 1'b0;
            crc_good     = 1'b0;
            kind         = KIND_NONE;
        endfunction

        function void expect_write(int unsigned addr, logic [7:0] data);
            result_t r;
            r = '0;
            r.log_addr   = ADDR_W'(addr);
            r.write_data = data;
            r.is_write   = 1'b1;
            expected_q.push_back(r);
        endfunction

        // Zero the first byte of every used slot
        function void clear_used_slots();
            for (int i = 0; i < int'(slot_index); i++)
                expect_write(i * SLOT_BYTES, 8'h00);
            slot_index = '0;
        endfunction

        // Predict the results of one accepted request
        function void note_request(logic [ACT_W-1:0] act, logic [7:0] b, logic last);
            int unsigned first;
            int unsigned tail;
            result_t     verdict;
            first = expected_q.size();
            case (act)
                ACT_WRITE:
                begin
                    if (kind == KIND_CHECK)
                        drop_frame();
                    if (kind == KIND_NONE)
                    begin
                        if (slot_index >= SLOT_COUNT)
                            clear_used_slots();
                        kind = KIND_WRITE;
                    end
                    // text past the limit is dropped
                    if (pos < TEXT_MAX)
                    begin
                        expect_write(int'(slot_index) * SLOT_BYTES + int'(pos), b);
                        crc = crc_next(crc, b);
                        pos++;
                    end
                    // terminator and CRC close the record
                    if (last)
                    begin
                        crc  = crc_next(crc, 8'h00);
                        tail = int'(slot_index) * SLOT_BYTES + int'(pos);
                        expect_write(tail, 8'h00);
                        expect_write(tail + 1, crc[15:8]);
                        expect_write(tail + 2, crc[7:0]);
                        slot_index++;
                        drop_frame();
                    end
                end
                ACT_CHECK:
                begin
                    if (kind == KIND_WRITE)
                        drop_frame();
                    kind = KIND_CHECK;
                    // bytes past the slot end are ignored
                    if (pos < SLOT_BYTES)
                    begin
                        if (pos == 0)
                            lead_nonzero = (b != 8'h00);
                        if (!term_seen)
                        begin
                            crc = crc_next(crc, b);
                            if (b == 8'h00)
                            begin
                                term_seen = 1'b1;
                                term_pos  = TPOS_W'(pos);
                            end
                        end
                        else if (int'(pos) <= int'(term_pos) + 2)
                        begin
                            crc = crc_next(crc, b);
                            if (int'(pos) == int'(term_pos) + 2)
                                crc_good = (crc == '0);
                        end
                        pos++;
                    end
                    if (last)
                    begin
                        verdict = '0;
                        verdict.slot_valid = lead_nonzero && term_seen &&
                                             (term_pos < SLOT_BYTES - 2) && crc_good;
                        if (verdict.slot_valid)
                            verdict.text_length = LEN_W'(term_pos);
                        expected_q.push_back(verdict);
                        drop_frame();
                    end
                end
                ACT_ERASE:
                begin
                    drop_frame();
                    clear_used_slots();
                end
                default:
                begin
                end
            endcase
            if (expected_q.size() > first)
                expected_q[expected_q.size() - 1].last_result = 1'b1;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        // Match one accepted result against the oldest prediction
        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result addr %0d data %02h write %0b",
                                 got.log_addr, got.write_data, got.is_write));
                return;
            end
            want = expected_q.pop_front();
            compare_field("log_addr", got.log_addr, want.log_addr);
            compare_field("write_data", got.write_data, want.write_data);
            compare_field("is_write", got.is_write, want.is_write);
            compare_field("slot_valid", got.slot_valid, want.slot_valid);
            compare_field("text_length", got.text_length, want.text_length);
            compare_field("last_result", got.last_result, want.last_result);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------------
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [ACT_W-1:0]  action    = ACT_WRITE;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              last_byte = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ADDR_W-1:0] log_addr;
    logic [BYTE_W-1:0] write_data;
    logic              is_write;
    logic              slot_valid;
    logic [LEN_W-1:0]  text_length;
    logic              last_result;

    log_scoreboard board;
    int unsigned   send_idle_pct = 0;
    int unsigned   stall_pct     = 0;
    int unsigned   hold_off_len  = 0;
    int unsigned   requests_sent = 0;
    int unsigned   quiet_cycles  = 0;

    crc_log_record_framer_checker_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .log_addr      (log_addr),
        .write_data    (write_data),
        .is_write      (is_write),
        .slot_valid    (slot_valid),
        .text_length   (text_length),
        .last_result   (last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Handshake monitors: pre-edge values decide acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && in_valid && in_ready)
            board.note_request(action, data_byte, last_byte);
        if (rst_n && out_valid && out_ready)
        begin
            got.log_addr      = log_addr;
            got.write_data    = write_data;
            got.is_write      = is_write;
            got.slot_valid    = slot_valid;
            got.text_length   = text_length;
            got.last_result   = last_result;
            board.check_result(got);
        end
    end

    // Watchdog: no progress on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL crc_log_record_framer_checker_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stalls, plus one long hold-off on demand
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Request drivers
    // ------------------------------------------------------------------------
    task automatic send_request(logic [ACT_W-1:0] act, logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= b;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
        if (act != ACT_UNUSED)
            requests_sent++;
    endtask

    // Text record; left open when close is 0
    task automatic send_text(int len, bit close);
        for (int i = 0; i < len; i++)
            send_request(ACT_WRITE, 8'($urandom_range(255)), close && (i == len - 1));
    endtask

    // Builds a slot image with a good CRC, damages it as asked, and checks it
    task automatic send_slot(int text_len, slot_flaw_t flaw);
        logic [7:0]       img[$];
        logic [CRC_W-1:0] c;
        int               cut;
        int               lead;
        int               target;
        c = CRC_INIT;
        for (int i = 0; i < text_len; i++)
            img.push_back(8'($urandom_range(255, 1)));
        img.push_back(8'h00);
        foreach (img[i])
            c = log_scoreboard::crc_next(c, img[i]);
        img.push_back(c[15:8]);
        img.push_back(c[7:0]);
        case (flaw)
            FLAW_CORRUPT:
            begin
                cut = $urandom_range(img.size() - 1);
                img[cut] = img[cut] ^ 8'($urandom_range(255, 1));
            end
            FLAW_LEAD_ZERO:
                img[0] = 8'h00;
            FLAW_EARLY:
            begin
                cut = $urandom_range(img.size() - 1, 1);
                while (img.size() > cut)
                    void'(img.pop_back());
            end
            FLAW_NO_TERM:
            begin
                img.delete();
                target = ($urandom_range(9) == 0) ? SLOT_BYTES : $urandom_range(8, 1);
                while (img.size() < target)
                    img.push_back(8'($urandom_range(255, 1)));
            end
            FLAW_PAD:
            begin
                // filler after the CRC, still inside the slot
                target = img.size() + $urandom_range(6, 2);
                while (img.size() < target)
                    img.push_back(8'($urandom_range(255)));
            end
            FLAW_LATE_TERM:
            begin
                // terminator too late for a CRC, then bytes past the slot end
                img.delete();
                lead = $urandom_range(SLOT_BYTES - 1, SLOT_BYTES - 2);
                for (int i = 0; i < lead; i++)
                    img.push_back(8'($urandom_range(255, 1)));
                img.push_back(8'h00);
                target = SLOT_BYTES + 1 + $urandom_range(3);
                while (img.size() < target)
                    img.push_back(8'($urandom_range(255)));
            end
            default:
            begin
            end
        endcase
        foreach (img[i])
            send_request(ACT_CHECK, img[i], i == img.size() - 1);
    endtask

    // Complete records, good and damaged slots, some open frames, erases and noise
    task automatic random_traffic(int unsigned count);
        int unsigned target;
        int unsigned roll;
        target = requests_sent + count;
        while (requests_sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 38)
                send_text($urandom_range(6, 1), 1'b1);
            else if (roll < 68)
                send_slot($urandom_range(6, 1), slot_flaw_t'($urandom_range(FLAW_NO_TERM)));
            else if (roll < 74)
                send_request(ACT_ERASE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            else if (roll < 82)
                send_text($urandom_range(4, 1), 1'b0);
            else if (roll < 88)
                send_request(ACT_CHECK, 8'($urandom_range(255)), 1'b0);
            else
                send_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                             1'($urandom_range(1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty erase, ignored action, zero and extreme text bytes
        send_request(ACT_ERASE, 8'h00, 1'b0);
        send_request(ACT_UNUSED, 8'hFF, 1'b1);
        send_request(ACT_WRITE, 8'h00, 1'b0);
        send_request(ACT_WRITE, 8'hFF, 1'b0);
        send_request(ACT_WRITE, 8'h80, 1'b1);
        send_request(ACT_WRITE, 8'h7F, 1'b1);
        // good slot, empty slot, no terminator with early end
        send_slot(1, FLAW_NONE);
        send_request(ACT_CHECK, 8'h00, 1'b1);
        send_request(ACT_CHECK, 8'h12, 1'b0);
        send_request(ACT_CHECK, 8'h34, 1'b1);
        // mode switches mid-frame, both ways
        send_request(ACT_WRITE, 8'h55, 1'b0);
        send_request(ACT_CHECK, 8'hAA, 1'b1);
        send_request(ACT_CHECK, 8'h01, 1'b0);
        send_request(ACT_WRITE, 8'h02, 1'b1);
        // bad CRC, then erase with slots in use
        send_slot(1, FLAW_CORRUPT);
        send_request(ACT_ERASE, 8'hFF, 1'b1);

        // no idling; includes an over-long record
        send_idle_pct = 0;
        stall_pct     = 0;
        send_text(TEXT_MAX + 1 + $urandom_range(1), 1'b1);
        random_traffic(6);

        // result side held off while one-byte records fill the log
        hold_off_len = HOLD_CYCLES;
        repeat (SLOT_COUNT + 2)
            send_text(1, 1'b1);

        // sender mostly idle; late terminator with overrun
        send_idle_pct = 87;
        stall_pct     = 0;
        send_slot(0, FLAW_LATE_TERM);
        random_traffic(6);

        // receiver mostly stalled; full-length good slot
        send_idle_pct = 0;
        stall_pct     = 87;
        send_slot(TEXT_MAX, FLAW_NONE);
        random_traffic(6);

        // both sides idle now and then
        send_idle_pct = 26;
        stall_pct     = 26;
        send_slot(2, FLAW_PAD);
        random_traffic(6);

        in_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("PASS crc_log_record_framer_checker_core");
        else
            $display("FAIL crc_log_record_framer_checker_core");
        $finish;
    end

endmodule

/* crc_log_record_framer_checker_core.f */
src/crclog_pkg.sv
src/crclog_crc_serial.sv
src/crclog_out_stage.sv
src/crc_log_record_framer_checker_core.sv
tb/crc_log_record_framer_checker_core_tb.sv
